// ===== src/sliding_window_client_rate_limiter_defines.svh =====
// Assertion macros used by the rate limiter sequencer RTL.
// No dependencies; expects clk_i and rst_ni in the scope of each use.
`ifndef SLIDING_WINDOW_CLIENT_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_CLIENT_RATE_LIMITER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property, held off during reset.
`define SWRL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked property, also checked during reset.
`define SWRL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SWRL_ASSERT(name, prop, msg)
`define SWRL_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== src/swrl_pkg.sv =====
// Package for the sliding window client rate limiter: types, codes, defaults.
// No dependencies.
package swrl_pkg;

  localparam int unsigned CLIENTS_DEF   = 16;
  localparam int unsigned LOG_DEPTH_DEF = 64;

  // Register indexes on the config port
  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_MAX_CONN_CL   = 3'd1,
    REG_MAX_CONN_TOT  = 3'd2,
    REG_MAX_REQ_CL    = 3'd3,
    REG_CONN_WINDOW   = 3'd4,
    REG_REQ_WINDOW    = 3'd5
  } reg_idx_e;

  // Verdict codes
  localparam logic [2:0] VERDICT_OK      = 3'd0;
  localparam logic [2:0] VERDICT_CLIENT  = 3'd1;
  localparam logic [2:0] VERDICT_GLOBAL  = 3'd2;
  localparam logic [2:0] VERDICT_NO_SLOT = 3'd3;
  localparam logic [2:0] VERDICT_CLEARED = 3'd4;

  // Mode bits: high bit means clear, low bit selects request over connection
  localparam int unsigned MODE_CLEAR_BIT = 1;
  localparam int unsigned MODE_REQ_BIT   = 0;
  localparam logic KIND_CONN = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DECIDE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        enable;
    logic [6:0]  max_conn_cl;
    logic [10:0] max_conn_tot;
    logic [6:0]  max_req_cl;
    logic [15:0] conn_window;
    logic [15:0] req_window;
  } cfg_t;

  typedef struct packed {
    logic        allowed;
    logic [2:0]  verdict;
    logic [6:0]  client_count;
    logic [10:0] total_count;
  } res_t;

endpackage

// ===== src/swrl_stamp_mem.sv =====
// Stamp log memory: one write port, one read port, registered read data.
// No dependencies.
module swrl_stamp_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/swrl_ctrl.sv =====
// Sequencer of the rate limiter: slot table, expiry sweep with compaction,
// limit checks and logging. Depends on swrl_pkg and the defines header.
`include "sliding_window_client_rate_limiter_defines.svh"
module swrl_ctrl #(
  parameter int unsigned CLIENTS   = 16,
  parameter int unsigned LOG_DEPTH = 64,
  parameter int unsigned AW        = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_mode_i,
  input  logic [31:0]        in_who_i,
  input  logic [31:0]        in_now_i,
  input  swrl_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output swrl_pkg::res_t     res_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  logic [31:0]        mem_rdata_i,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [31:0]        mem_wdata_o
);
  import swrl_pkg::*;

  localparam int unsigned SW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned TW = $clog2(CLIENTS * LOG_DEPTH + 1);

  function automatic logic [AW-1:0] log_addr(logic k, logic [SW-1:0] s, logic [CW-1:0] i);
    log_addr = AW'(k) * AW'(CLIENTS * LOG_DEPTH) + AW'(s) * AW'(LOG_DEPTH) + AW'(i);
  endfunction

  state_e state_q, state_d;

  logic              valid_q [2][CLIENTS];
  logic              valid_d [2][CLIENTS];
  logic [CW-1:0]     cnt_q   [2][CLIENTS];
  logic [CW-1:0]     cnt_d   [2][CLIENTS];
  logic [31:0]       addr_q  [2][CLIENTS];
  logic [31:0]       addr_d  [2][CLIENTS];

  logic              kind_q, kind_d;
  logic [31:0]       who_q, who_d;
  logic [31:0]       now_q, now_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     keep_q, keep_d;
  logic [TW-1:0]     total_q, total_d;
  logic [CW-1:0]     mine_q, mine_d;
  logic              hit_q, hit_d;
  logic [SW-1:0]     hit_slot_q, hit_slot_d;
  logic              free_q, free_d;
  logic [SW-1:0]     free_slot_q, free_slot_d;
  res_t              res_q, res_d;

  // Control and slot table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        for (int s = 0; s < CLIENTS; s++) begin
          valid_q[k][s] <= 1'b0;
          cnt_q[k][s]   <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    kind_q      <= kind_d;
    who_q       <= who_d;
    now_q       <= now_d;
    slot_q      <= slot_d;
    rd_idx_q    <= rd_idx_d;
    keep_q      <= keep_d;
    total_q     <= total_d;
    mine_q      <= mine_d;
    hit_q       <= hit_d;
    hit_slot_q  <= hit_slot_d;
    free_q      <= free_d;
    free_slot_q <= free_slot_d;
    res_q       <= res_d;
  end

  // Next state and datapath
  always_comb begin
    logic [CW-1:0] n;
    logic          in_win;
    logic [CW-1:0] keep_nxt;
    int unsigned   climit;
    logic [2:0]    verdict;
    logic [SW-1:0] tslot;
    int unsigned   m_out;
    int unsigned   t_out;

    state_d     = state_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    kind_d      = kind_q;
    who_d       = who_q;
    now_d       = now_q;
    slot_d      = slot_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    keep_d      = keep_q;
    total_d     = total_q;
    mine_d      = mine_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    free_d      = free_q;
    free_slot_d = free_slot_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = log_addr(kind_q, slot_q, rd_idx_q);
    mem_we_o    = 1'b0;
    mem_waddr_o = log_addr(kind_q, slot_q, keep_q);
    mem_wdata_o = mem_rdata_i;

    n        = valid_q[kind_q][slot_q] ? cnt_q[kind_q][slot_q] : '0;
    in_win   = (32'(now_q - mem_rdata_i) <=
                32'((kind_q == KIND_CONN) ? cfg_i.conn_window : cfg_i.req_window));
    keep_nxt = keep_q;
    climit   = 0;
    verdict  = VERDICT_OK;
    tslot    = '0;
    m_out    = 0;
    t_out    = 0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d      = in_mode_i[MODE_REQ_BIT];
          who_d       = in_who_i;
          now_d       = in_now_i;
          slot_d      = '0;
          rd_idx_d    = '0;
          keep_d      = '0;
          total_d     = '0;
          mine_d      = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          hit_slot_d  = '0;
          free_slot_d = '0;
          if (in_mode_i[MODE_CLEAR_BIT]) begin
            for (int k = 0; k < 2; k++) begin
              for (int s = 0; s < CLIENTS; s++) begin
                valid_d[k][s] = 1'b0;
                cnt_d[k][s]   = '0;
              end
            end
            res_d   = '{allowed: 1'b0, verdict: VERDICT_CLEARED,
                        client_count: '0, total_count: '0};
            state_d = ST_OUT;
          end else if (!cfg_i.enable) begin
            res_d   = '{allowed: 1'b1, verdict: VERDICT_OK,
                        client_count: '0, total_count: '0};
            state_d = ST_OUT;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        // Evaluate the stamp read last cycle; kept stamps move down
        if (pend_q && in_win) begin
          mem_we_o = 1'b1;
          keep_nxt = keep_q + CW'(1);
        end
        keep_d = keep_nxt;
        // Issue the next read of this slot
        if (rd_idx_q < n) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          rd_idx_d = rd_idx_q + CW'(1);
        end else if (!pend_q) begin
          // Slot done: store count, free if empty, gather totals and lookups
          cnt_d[kind_q][slot_q]   = keep_q;
          valid_d[kind_q][slot_q] = (keep_q != '0);
          if (keep_q != '0) begin
            total_d = total_q + TW'(keep_q);
            if (!hit_q && addr_q[kind_q][slot_q] == who_q) begin
              hit_d      = 1'b1;
              hit_slot_d = slot_q;
              mine_d     = keep_q;
            end
          end else if (!free_q) begin
            free_d      = 1'b1;
            free_slot_d = slot_q;
          end
          rd_idx_d = '0;
          keep_d   = '0;
          if (slot_q == SW'(CLIENTS - 1)) begin
            state_d = ST_DECIDE;
          end else begin
            slot_d = slot_q + SW'(1);
          end
        end
      end

      ST_DECIDE: begin
        climit = 32'((kind_q == KIND_CONN) ? cfg_i.max_conn_cl : cfg_i.max_req_cl);
        if (climit > LOG_DEPTH) begin
          climit = LOG_DEPTH;
        end
        if (32'(mine_q) >= climit) begin
          verdict = VERDICT_CLIENT;
        end else if (kind_q == KIND_CONN && 32'(total_q) >= 32'(cfg_i.max_conn_tot)) begin
          verdict = VERDICT_GLOBAL;
        end else if (!hit_q && !free_q) begin
          verdict = VERDICT_NO_SLOT;
        end
        m_out = 32'(mine_q);
        t_out = 32'(total_q);
        if (verdict == VERDICT_OK) begin
          tslot       = hit_q ? hit_slot_q : free_slot_q;
          mem_we_o    = 1'b1;
          mem_waddr_o = log_addr(kind_q, tslot, hit_q ? mine_q : '0);
          mem_wdata_o = now_q;
          valid_d[kind_q][tslot] = 1'b1;
          addr_d[kind_q][tslot]  = who_q;
          cnt_d[kind_q][tslot]   = (hit_q ? mine_q : '0) + CW'(1);
          m_out = m_out + 1;
          t_out = t_out + 1;
        end
        res_d.allowed      = (verdict == VERDICT_OK);
        res_d.verdict      = verdict;
        res_d.client_count = 7'((m_out > 127) ? 127 : m_out);
        res_d.total_count  = 11'((t_out > 2047) ? 2047 : t_out);
        state_d = ST_OUT;
      end

      ST_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  // Checks
  `SWRL_ASSERT(a_no_write_idle, (state_q == ST_IDLE || state_q == ST_OUT) |-> !mem_we_o, "log written outside sweep or decide")
  `SWRL_ASSERT(a_pend_from_sweep, pend_q |-> ($past(state_q) == ST_SWEEP && state_q == ST_SWEEP), "pending read outside sweep")
  `SWRL_ASSERT(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> state_q != ST_IDLE, "accepted item not started")
  `SWRL_ASSERT_ALWAYS(a_ready_idle, in_ready_o |-> (state_q == ST_IDLE), "input ready outside idle")
endmodule

// ===== src/sliding_window_client_rate_limiter.sv =====
// Top level of the sliding window client rate limiter: config registers,
// output register, sequencer and stamp memory. Depends on swrl_pkg, swrl_ctrl and swrl_stamp_mem.
//
//  channel   | direction | tdata (low bit up)                      | tuser
//  s_axis    | in        | client_address[31:0], now_time[63:32]  | mode[1:0]
//  m_axis    | out       | allowed, verdict, client_count, total  | -
//  cfg       | in        | write enable, 3-bit index, 16-bit data | -
//
// Clear and disabled items skip the sweep and go from idle straight to the output state.
// Attempts first run the expiry sweep, which reads every logged stamp of the kind
// once through the memory read port.
// Reset is asynchronous and empties all slots; log memory needs no clearing.
// The output register holds a result while the next item is accepted.
module sliding_window_client_rate_limiter #(
  parameter int unsigned CLIENTS   = swrl_pkg::CLIENTS_DEF,
  parameter int unsigned LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // client_address[31:0], now_time[63:32]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // allowed[0], verdict[3:1], client_count[10:4],
                                      // total_count[21:11], zero[23:22]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import swrl_pkg::*;

  localparam int unsigned DEPTH = 2 * CLIENTS * LOG_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t          cfg_q;
  res_t          res, out_q;
  logic          out_vld_q;
  logic          res_valid, res_ready;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0]   mem_rdata, mem_wdata;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: 1'b0, max_conn_cl: 7'd10, max_conn_tot: 11'd100,
                 max_req_cl: 7'd64, conn_window: 16'd60, req_window: 16'd60};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ENABLE:       cfg_q.enable       <= cfg_data_i[0];
        REG_MAX_CONN_CL:  cfg_q.max_conn_cl  <= cfg_data_i[6:0];
        REG_MAX_CONN_TOT: cfg_q.max_conn_tot <= cfg_data_i[10:0];
        REG_MAX_REQ_CL:   cfg_q.max_req_cl   <= cfg_data_i[6:0];
        REG_CONN_WINDOW:  cfg_q.conn_window  <= cfg_data_i;
        REG_REQ_WINDOW:   cfg_q.req_window   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Output register
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.total_count, out_q.client_count,
                          out_q.verdict, out_q.allowed};

  swrl_ctrl #(
    .CLIENTS   (CLIENTS),
    .LOG_DEPTH (LOG_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_who_i    (s_axis_tdata[31:0]),
    .in_now_i    (s_axis_tdata[63:32]),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  swrl_stamp_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the sliding window client rate limiter: directed and random
// connection, request and clear items checked against a behavioral predictor.
// Depends on swrl_pkg and sliding_window_client_rate_limiter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swrl_pkg::*;

  localparam int unsigned NCL   = 16;
  localparam int unsigned DEPTH = 64;
  localparam logic [1:0] MODE_CONN  = 2'd0;
  localparam logic [1:0] MODE_REQ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_THREE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  // Predicted admission result, one per item
  typedef struct packed {
    logic        allowed;
    logic [2:0]  verdict;
    logic [6:0]  client_count;
    logic [10:0] total_count;
  } verdict_t;

  // Per-kind client logs
  typedef struct {
    bit          used [NCL];
    logic [31:0] addr [NCL];
    int unsigned cnt  [NCL];
    logic [31:0] stamp [NCL][DEPTH];
  } kind_log_t;

  class admission_board;
    kind_log_t   conn_log, req_log;
    cfg_t        cfg;
    verdict_t    pending[$];
    int unsigned errors, checked, admitted;

    function void wipe();
      for (int s = 0; s < NCL; s++) begin
        conn_log.used[s] = 0; conn_log.cnt[s] = 0;
        req_log.used[s] = 0;  req_log.cnt[s] = 0;
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_ENABLE:       cfg.enable = v[0];
        REG_MAX_CONN_CL:  cfg.max_conn_cl = v[6:0];
        REG_MAX_CONN_TOT: cfg.max_conn_tot = v[10:0];
        REG_MAX_REQ_CL:   cfg.max_req_cl = v[6:0];
        REG_CONN_WINDOW:  cfg.conn_window = v;
        REG_REQ_WINDOW:   cfg.req_window = v;
        default: ;
      endcase
    endfunction

    // Expire stamps, look up the client, decide and log
    function verdict_t admit(ref kind_log_t lg, input logic [31:0] who, now,
                             logic [15:0] win, int unsigned climit,
                             bit use_glob, int unsigned glimit);
      verdict_t r;
      int unsigned total, mine, keep;
      int slot, free_s;
      logic [2:0] v;
      total = 0; mine = 0; slot = -1; free_s = -1; v = VERDICT_OK;
      for (int s = 0; s < NCL; s++) begin
        if (!lg.used[s]) begin
          lg.cnt[s] = 0;
        end else begin
          keep = 0;
          for (int i = 0; i < lg.cnt[s]; i++)
            if (32'(now - lg.stamp[s][i]) <= {16'd0, win}) begin
              lg.stamp[s][keep] = lg.stamp[s][i];
              keep++;
            end
          lg.cnt[s] = keep;
          if (keep == 0) lg.used[s] = 0;
        end
      end
      for (int s = 0; s < NCL; s++) begin
        if (lg.used[s]) begin
          total += lg.cnt[s];
          if (lg.addr[s] == who && slot < 0) begin
            slot = s; mine = lg.cnt[s];
          end
        end else if (free_s < 0) begin
          free_s = s;
        end
      end
      if (climit > DEPTH) climit = DEPTH;
      if (mine >= climit) v = VERDICT_CLIENT;
      else if (use_glob && total >= glimit) v = VERDICT_GLOBAL;
      else if (slot < 0 && free_s < 0) v = VERDICT_NO_SLOT;
      if (v == VERDICT_OK) begin
        if (slot < 0) begin
          slot = free_s; lg.used[slot] = 1; lg.addr[slot] = who; lg.cnt[slot] = 0;
        end
        lg.stamp[slot][lg.cnt[slot]] = now;
        lg.cnt[slot]++;
        mine++; total++;
        admitted++;
      end
      r.allowed = (v == VERDICT_OK);
      r.verdict = v;
      r.client_count = 7'(mine);
      r.total_count = 11'(total);
      return r;
    endfunction

    function void note_item(logic [1:0] mode, logic [31:0] who, now);
      verdict_t r;
      if (mode[MODE_CLEAR_BIT]) begin
        wipe();
        r = '{1'b0, VERDICT_CLEARED, 7'd0, 11'd0};
      end else if (!cfg.enable) begin
        r = '{1'b1, VERDICT_OK, 7'd0, 11'd0};
      end else if (mode[MODE_REQ_BIT] == KIND_CONN) begin
        r = admit(conn_log, who, now, cfg.conn_window, cfg.max_conn_cl, 1,
                  cfg.max_conn_tot);
      end else begin
        r = admit(req_log, who, now, cfg.req_window, cfg.max_req_cl, 0, 0);
      end
      pending = {pending, r};
    endfunction

    function void check_result(logic [23:0] d);
      verdict_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.allowed) begin
        $error("allowed: expected %0d, got %0d", e.allowed, d[0]); errors++;
      end
      if (d[3:1] !== e.verdict) begin
        $error("verdict: expected %0d, got %0d", e.verdict, d[3:1]); errors++;
      end
      if (d[10:4] !== e.client_count) begin
        $error("client_count: expected %0d, got %0d", e.client_count, d[10:4]);
        errors++;
      end
      if (d[21:11] !== e.total_count) begin
        $error("total_count: expected %0d, got %0d", e.total_count, d[21:11]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  admission_board board = new();
  int unsigned send_idle_pct, recv_stall_pct, cycles;
  logic [31:0] clock_now;
  logic [31:0] hosts[24];

  always #2 clk_i = ~clk_i;

  sliding_window_client_rate_limiter dut (.*);

  // Receiver: random stall, check on handshake
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Valid stays high after an accept; the next item may idle it at random, and drain() takes it down
  task automatic send_item(logic [1:0] mode, logic [31:0] who, now);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {now, who};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(mode, who, now);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    board.set_reg(idx, v);
  endtask

  task automatic setup(bit en, logic [6:0] ccl, logic [10:0] ctot, logic [6:0] rcl,
                       logic [15:0] cw, logic [15:0] rw);
    drain();
    write_reg(REG_ENABLE, {15'd0, en});
    write_reg(REG_MAX_CONN_CL, {9'd0, ccl});
    write_reg(REG_MAX_CONN_TOT, {5'd0, ctot});
    write_reg(REG_MAX_REQ_CL, {9'd0, rcl});
    write_reg(REG_CONN_WINDOW, cw);
    write_reg(REG_REQ_WINDOW, rw);
    cfg_we_i <= 0;
  endtask

  // One random item: mostly attempts from a small client pool and slowly advancing time
  task automatic random_item();
    logic [1:0] mode;
    logic [31:0] who;
    int unsigned p;
    p = $urandom_range(99);
    mode = (p < 2) ? MODE_CLEAR : (p < 3) ? MODE_THREE : (p < 55) ? MODE_CONN : MODE_REQ;
    who = ($urandom_range(9) == 0) ? $urandom() : hosts[$urandom_range(23)];
    if ($urandom_range(19) == 0) clock_now = clock_now + $urandom();
    else clock_now = clock_now + $urandom_range(3);
    send_item(mode, who, clock_now);
  endtask

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (n) random_item();
  endtask

  initial begin
    board.cfg = '{1'b0, 7'd10, 11'd100, 7'd64, 16'd60, 16'd60};
    board.wipe();
    for (int i = 0; i < 24; i++) hosts[i] = (i < 2) ? {32{i[0]}} : $urandom();
    clock_now = $urandom();
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: disabled, both clear codes
    send_item(MODE_CONN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_REQ, 32'h0, 32'h0);
    send_item(MODE_CLEAR, 32'h1234_5678, 32'h0);
    send_item(MODE_THREE, 32'h0, 32'hFFFF_FFFF);
    // Client limit then wrap-around expiry, with saturated oversize request limit
    setup(1, 7'd2, 11'd3, 7'd127, 16'd5, 16'd0);
    send_item(MODE_CONN, 32'h0A00_0001, 32'hFFFF_FFFE);
    send_item(MODE_CONN, 32'h0A00_0001, 32'hFFFF_FFFF);
    send_item(MODE_CONN, 32'h0A00_0001, 32'h0000_0002);
    send_item(MODE_CONN, 32'h0A00_0002, 32'h0000_0003);
    send_item(MODE_CONN, 32'h0A00_0003, 32'h0000_0003);
    send_item(MODE_CONN, 32'h0A00_0001, 32'h0000_0005);
    send_item(MODE_REQ, 32'h0A00_0001, 32'h0000_0005);
    send_item(MODE_REQ, 32'h0A00_0001, 32'h0000_0006);
    // Zero limits deny everything
    setup(1, 7'd0, 11'd0, 7'd0, 16'hFFFF, 16'hFFFF);
    send_item(MODE_CONN, 32'h1, 32'h10);
    send_item(MODE_REQ, 32'h1, 32'h10);
    // Slot exhaustion: 17 distinct clients, full-length window
    setup(1, 7'd64, 11'd1024, 7'd64, 16'hFFFF, 16'hFFFF);
    send_item(MODE_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < 17; i++) send_item(MODE_REQ, 32'hC0A8_0000 + i, 32'h100);
    // Pause until every result has arrived
    drain();

    // Random phases at several settings
    setup(1, 7'd4, 11'd20, 7'd6, 16'd8, 16'd12);
    random_phase(110, 0, 0);
    setup(1, 7'd64, 11'd1024, 7'd64, 16'd40, 16'd40);
    random_phase(110, 53, 0);
    setup(1, 7'd127, 11'd2047, 7'd3, 16'd0, 16'hFFFF);
    random_phase(110, 0, 53);
    setup(1, 7'd2, 11'd5, 7'd1, 16'd3, 16'd2);
    random_phase(110, 31, 31);
    setup(0, 7'd10, 11'd100, 7'd64, 16'd60, 16'd60);
    random_phase(50, 31, 31);
    setup(1, 7'd10, 11'd100, 7'd64, 16'd60, 16'd60);
    random_phase(50, 0, 0);

    drain();
    $display("Covered %0d results (%0d admitted attempts) over six settings,",
             board.checked, board.admitted);
    $display("with clear, disabled, limit, expiry and slot-exhaustion cases.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/swrl_pkg.sv
src/swrl_stamp_mem.sv
src/swrl_ctrl.sv
src/sliding_window_client_rate_limiter.sv
test/tb.sv
